// ===== design/ttlb_pkg.sv =====
// Package for the tagged TLB: operation kinds and controller-to-datapath commands.
`default_nettype none
package ttlb_pkg;

  localparam logic [2:0] KIND_LOOKUP    = 3'd0;
  localparam logic [2:0] KIND_INSERT    = 3'd1;
  localparam logic [2:0] KIND_INV_PAGE  = 3'd2;
  localparam logic [2:0] KIND_INV_PROC  = 3'd3;
  localparam logic [2:0] KIND_INV_FRAME = 3'd4;

  typedef enum logic [1:0] {
    DP_IDLE,
    DP_LOAD,
    DP_SWEEP,
    DP_EXEC
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } dp_cmd_t;

endpackage
`default_nettype wire

// ===== design/ttlb_ctrl.sv =====
// Sequencer for the tagged TLB: input and output handshakes and the removal sweep.
`default_nettype none
module ttlb_ctrl
  import ttlb_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [2:0]                 kind,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output dp_cmd_t                         cmd,
  output logic [$clog2(ENTRIES)-1:0]      sweep_idx
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_EXEC,
    S_PUSH
  } state_t;

  state_t          state;
  logic [2:0]      kind_q;
  logic [IW-1:0]   cnt;
  logic            accept;
  logic            out_free;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign sweep_idx = cnt;

  always_comb begin
    cmd.load_out = (state == S_PUSH) && out_free;
    unique case (state)
      S_IDLE:  cmd.op = accept ? DP_LOAD : DP_IDLE;
      S_SWEEP: cmd.op = DP_SWEEP;
      S_EXEC:  cmd.op = DP_EXEC;
      default: cmd.op = DP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      kind_q    <= KIND_LOOKUP;
    end else begin
      if (state == S_PUSH && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind_q <= kind;
            cnt    <= '0;
            if (kind == KIND_INSERT || kind == KIND_INV_PROC || kind == KIND_INV_FRAME) begin
              state <= S_SWEEP;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_IDX) begin
            state <= (kind_q == KIND_INSERT) ? S_EXEC : S_PUSH;
          end
        end
        S_EXEC: state <= S_PUSH;
        S_PUSH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input not stalled while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE)) else $error("accepted word did not start work");
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && !out_valid) |=> out_valid) else $error("result word not shown");

endmodule
`default_nettype wire

// ===== design/ttlb_dp.sv =====
// Datapath for the tagged TLB: entry storage, parallel match and LRU rank update.
`default_nettype none
module ttlb_dp
  import ttlb_pkg::*;
#(
  parameter int ENTRIES     = 16,
  parameter int PROC_WIDTH  = 8,
  parameter int PAGE_WIDTH  = 20,
  parameter int FRAME_WIDTH = 20
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  dp_cmd_t                         cmd,
  input  wire logic [$clog2(ENTRIES)-1:0] sweep_idx,
  input  wire logic [2:0]                 kind,
  input  wire logic [PROC_WIDTH-1:0]      proc_id,
  input  wire logic [PAGE_WIDTH-1:0]      virt_page,
  input  wire logic [FRAME_WIDTH-1:0]     phys_frame,
  output logic                            hit,
  output logic [FRAME_WIDTH-1:0]          frame_out,
  output logic                            displaced
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  logic                   valid [ENTRIES];
  logic [IW-1:0]          rank  [ENTRIES];
  logic [PROC_WIDTH-1:0]  eproc [ENTRIES];
  logic [PAGE_WIDTH-1:0]  epage [ENTRIES];
  logic [FRAME_WIDTH-1:0] eframe[ENTRIES];

  logic [2:0]             kind_q;
  logic [PROC_WIDTH-1:0]  proc_q;
  logic [PAGE_WIDTH-1:0]  page_q;
  logic [FRAME_WIDTH-1:0] frame_q;
  logic                   res_hit, res_disp;
  logic [FRAME_WIDTH-1:0] res_frame;

  logic          found, has_free;
  logic [IW-1:0] midx, free_idx, victim_idx, slot;
  logic          sweep_hit;
  logic          rem_en, prom_en, fill_en, upd_en;
  logic [IW-1:0] rem_idx, prom_idx;
  logic [IW-1:0] rem_r, prom_r;

  // Lowest-index match, lowest-index free entry, and the entry of rank LAST.
  always_comb begin
    found      = 1'b0;
    has_free   = 1'b0;
    midx       = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (valid[k] && eproc[k] == proc_q && epage[k] == page_q) begin
        found = 1'b1;
        midx  = IW'(k);
      end
      if (!valid[k]) begin
        has_free = 1'b1;
        free_idx = IW'(k);
      end
      if (rank[k] == LAST) victim_idx = IW'(k);
    end
    slot = has_free ? free_idx : victim_idx;
  end

  always_comb begin
    sweep_hit = valid[sweep_idx] &&
                ((kind_q == KIND_INV_PROC) ? (eproc[sweep_idx] == proc_q)
                                           : (eframe[sweep_idx] == frame_q));
    rem_en   = 1'b0;
    rem_idx  = sweep_idx;
    prom_en  = 1'b0;
    prom_idx = midx;
    prom_r   = rank[midx];
    fill_en  = 1'b0;
    upd_en   = 1'b0;
    if (cmd.op == DP_SWEEP) begin
      rem_en = sweep_hit;
    end else if (cmd.op == DP_EXEC) begin
      unique case (kind_q)
        KIND_LOOKUP:   prom_en = found;
        KIND_INSERT: begin
          prom_en = 1'b1;
          if (found) begin
            upd_en = 1'b1;
          end else begin
            fill_en  = 1'b1;
            prom_idx = slot;
            prom_r   = LAST;
          end
        end
        KIND_INV_PAGE: begin
          rem_en  = found;
          rem_idx = midx;
        end
        default: ;
      endcase
    end
    rem_r = rank[rem_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ENTRIES; k++) begin
        valid[k] <= 1'b0;
        rank[k]  <= LAST;
      end
    end else begin
      for (int k = 0; k < ENTRIES; k++) begin
        if (rem_en) begin
          if (IW'(k) == rem_idx) begin
            valid[k] <= 1'b0;
            rank[k]  <= LAST;
          end else if (valid[k] && rank[k] > rem_r) begin
            rank[k] <= rank[k] - 1'b1;
          end
        end
        if (prom_en) begin
          if (IW'(k) == prom_idx) begin
            rank[k] <= '0;
            if (fill_en) valid[k] <= 1'b1;
          end else if (valid[k] && rank[k] < prom_r) begin
            rank[k] <= rank[k] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fill_en) begin
      eproc[prom_idx] <= proc_q;
      epage[prom_idx] <= page_q;
    end
    if (fill_en || upd_en) eframe[prom_idx] <= frame_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      kind_q    <= kind;
      proc_q    <= proc_id;
      page_q    <= virt_page;
      frame_q   <= phys_frame;
      res_hit   <= 1'b0;
      res_frame <= '0;
      res_disp  <= 1'b0;
    end else if (cmd.op == DP_EXEC) begin
      if (kind_q == KIND_LOOKUP && found) begin
        res_hit   <= 1'b1;
        res_frame <= eframe[midx];
      end
      if (kind_q == KIND_INSERT && !found) res_disp <= valid[slot];
    end
    if (cmd.load_out) begin
      hit       <= res_hit;
      frame_out <= res_frame;
      displaced <= res_disp;
    end
  end

endmodule
`default_nettype wire

// ===== design/tagged_tlb_lru.sv =====
// Fully associative TLB with process tags and exact LRU ranking.
// Input channel (in_valid/in_stall) carries one operation word: kind,
// proc_id, virt_page, phys_frame. Output channel (out_valid/out_stall)
// returns one result word per operation: hit, frame_out, displaced.
// Lookup and invalidate by page skip the sweep and run the execute step.
// Insert, invalidate by process and invalidate by frame run a removal
// sweep over the entries, one entry per cycle; the sweep is set by the
// single remove unit that closes rank gaps. Insert then runs the execute
// step. One operation is in flight at a time; the next word
// is taken as soon as the result sits in the output register, even while
// the receiver stalls it. A stalled result holds until taken, and the
// next result waits behind it. Reset invalidates all entries at once
// and needs no clearing pass.
`default_nettype none
module tagged_tlb_lru
  import ttlb_pkg::*;
#(
  parameter int ENTRIES     = 16,
  parameter int PROC_WIDTH  = 8,
  parameter int PAGE_WIDTH  = 20,
  parameter int FRAME_WIDTH = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [2:0]             kind,
  input  wire logic [PROC_WIDTH-1:0]  proc_id,
  input  wire logic [PAGE_WIDTH-1:0]  virt_page,
  input  wire logic [FRAME_WIDTH-1:0] phys_frame,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        hit,
  output logic [FRAME_WIDTH-1:0]      frame_out,
  output logic                        displaced
);

  dp_cmd_t                    cmd;
  logic [$clog2(ENTRIES)-1:0] sweep_idx;

  ttlb_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .kind, .out_valid, .out_stall,
    .cmd, .sweep_idx
  );

  ttlb_dp #(
    .ENTRIES(ENTRIES), .PROC_WIDTH(PROC_WIDTH),
    .PAGE_WIDTH(PAGE_WIDTH), .FRAME_WIDTH(FRAME_WIDTH)
  ) u_dp (
    .clk, .rst, .cmd, .sweep_idx, .kind, .proc_id, .virt_page, .phys_frame,
    .hit, .frame_out, .displaced
  );

endmodule
`default_nettype wire

// ===== tb/tagged_tlb_lru_tb.sv =====
// Self-checking testbench for the tagged TLB with LRU replacement.
`timescale 1ns / 100ps
module tagged_tlb_lru_tb;
  import ttlb_pkg::*;

  localparam int ENTRIES = 16;
  localparam int LAST_RANK = ENTRIES - 1;
  localparam int RANDOM_WORDS = 1800;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  pid;
    logic [19:0] page;
    logic [19:0] frame;
  } op_word_t;

  typedef struct packed {
    logic        hit;
    logic [19:0] frame;
    logic        displaced;
  } res_word_t;

  // One row of the directed table; known marks a typed-in expected result.
  typedef struct packed {
    op_word_t  op;
    logic      known;
    res_word_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] kind = KIND_LOOKUP;
  logic [7:0] proc_id = '0;
  logic [19:0] virt_page = '0;
  logic [19:0] phys_frame = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic [19:0] frame_out;
  logic displaced;

  tagged_tlb_lru uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .proc_id(proc_id), .virt_page(virt_page), .phys_frame(phys_frame),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .frame_out(frame_out), .displaced(displaced)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the translation table.
  logic        tlb_valid [ENTRIES];
  logic [7:0]  tlb_pid   [ENTRIES];
  logic [19:0] tlb_page  [ENTRIES];
  logic [19:0] tlb_frame [ENTRIES];
  int          tlb_rank  [ENTRIES];

  res_word_t pending_results[$];
  int errors = 0;
  int cycles = 0;

  task automatic report_mismatch(input string what, input logic [19:0] got,
                                 input logic [19:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    errors++;
  endtask

  function automatic int find_entry(input logic [7:0] pid, input logic [19:0] page);
    for (int k = 0; k < ENTRIES; k++)
      if (tlb_valid[k] && tlb_pid[k] == pid && tlb_page[k] == page) return k;
    return -1;
  endfunction

  function automatic void make_recent(input int idx);
    int r;
    r = tlb_rank[idx];
    for (int k = 0; k < ENTRIES; k++)
      if (k != idx && tlb_valid[k] && tlb_rank[k] < r) tlb_rank[k]++;
    tlb_rank[idx] = 0;
  endfunction

  function automatic void drop_entry(input int idx);
    int r;
    r = tlb_rank[idx];
    tlb_valid[idx] = 1'b0;
    tlb_rank[idx] = LAST_RANK;
    for (int k = 0; k < ENTRIES; k++)
      if (tlb_valid[k] && tlb_rank[k] > r) tlb_rank[k]--;
  endfunction

  function automatic void drop_frame(input logic [19:0] frame);
    for (int k = 0; k < ENTRIES; k++)
      if (tlb_valid[k] && tlb_frame[k] == frame) drop_entry(k);
  endfunction

  function automatic int choose_slot();
    int best;
    int oldest;
    best = 0;
    oldest = 0;
    for (int k = 0; k < ENTRIES; k++)
      if (!tlb_valid[k]) return k;
    for (int k = 0; k < ENTRIES; k++)
      if (tlb_rank[k] >= oldest) begin
        oldest = tlb_rank[k];
        best = k;
      end
    return best;
  endfunction

  function automatic res_word_t translate(input op_word_t op);
    res_word_t r;
    int idx;
    r = '0;
    case (op.kind)
      KIND_LOOKUP: begin
        idx = find_entry(op.pid, op.page);
        if (idx >= 0) begin
          r.hit = 1'b1;
          r.frame = tlb_frame[idx];
          make_recent(idx);
        end
      end
      KIND_INSERT: begin
        drop_frame(op.frame);
        idx = find_entry(op.pid, op.page);
        if (idx >= 0) begin
          tlb_frame[idx] = op.frame;
          make_recent(idx);
        end else begin
          idx = choose_slot();
          r.displaced = tlb_valid[idx];
          tlb_valid[idx] = 1'b1;
          tlb_pid[idx] = op.pid;
          tlb_page[idx] = op.page;
          tlb_frame[idx] = op.frame;
          tlb_rank[idx] = LAST_RANK;
          make_recent(idx);
        end
      end
      KIND_INV_PAGE: begin
        idx = find_entry(op.pid, op.page);
        if (idx >= 0) drop_entry(idx);
      end
      KIND_INV_PROC: begin
        for (int k = 0; k < ENTRIES; k++)
          if (tlb_valid[k] && tlb_pid[k] == op.pid) drop_entry(k);
      end
      KIND_INV_FRAME: drop_frame(op.frame);
      default: ;
    endcase
    return r;
  endfunction

  // Small pools of tags, pages and frames so that random words hit and collide.
  function automatic op_word_t random_word();
    op_word_t op;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) op.kind = KIND_LOOKUP;
    else if (sel < 75) op.kind = KIND_INSERT;
    else if (sel < 84) op.kind = KIND_INV_PAGE;
    else if (sel < 89) op.kind = KIND_INV_PROC;
    else if (sel < 96) op.kind = KIND_INV_FRAME;
    else op.kind = 3'(
        $urandom_range(5, 7));
    if ($urandom_range(0, 9) == 0) begin
      op.pid = 8'($urandom);
      op.page = 20'($urandom);
      op.frame = 20'($urandom);
    end else begin
      op.pid = 8'($urandom_range(0, 3)) ^ ($urandom_range(0, 1) ? 8'hff : 8'h00);
      op.page = 20'($urandom_range(0, 11)) ^ ($urandom_range(0, 1) ? 20'hfffff : 20'h0);
      op.frame = 20'($urandom_range(0, 23)) ^ ($urandom_range(0, 1) ? 20'hfffff : 20'h0);
    end
    return op;
  endfunction

  task automatic send_word(input op_word_t op, input logic known, input res_word_t want);
    res_word_t r;
    kind <= op.kind;
    proc_id <= op.pid;
    virt_page <= op.page;
    phys_frame <= op.frame;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    r = translate(op);
    if (known && r !== want) begin
      $display("directed row disagrees with predictor at cycle %0d", cycles);
      errors++;
    end
    pending_results.push_back(known ? want : r);
  endtask

  // Receiver stalls on a pattern of its own, with quiet stretches.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) out_stall <= 1'b0;
    else if ((cycles / 300) % 3 == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 40);
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", frame_out, 20'h0);
      end else begin
        res_word_t want;
        want = pending_results.pop_front();
        if (hit !== want.hit) report_mismatch("hit", 20'(hit), 20'(want.hit));
        if (frame_out !== want.frame) report_mismatch("frame_out", frame_out, want.frame);
        if (displaced !== want.displaced)
          report_mismatch("displaced", 20'(displaced), 20'(want.displaced));
      end
    end
  end

  dir_row_t directed [] = '{
    '{'{KIND_LOOKUP, 8'h00, 20'h00000, 20'h00000}, 1'b1, '{1'b0, 20'h0, 1'b0}},
    '{'{KIND_INSERT, 8'hff, 20'hfffff, 20'hfffff}, 1'b1, '{1'b0, 20'h0, 1'b0}},
    '{'{KIND_LOOKUP, 8'hff, 20'hfffff, 20'h00000}, 1'b1, '{1'b1, 20'hfffff, 1'b0}},
    '{'{KIND_INSERT, 8'h00, 20'h00000, 20'h00000}, 1'b1, '{1'b0, 20'h0, 1'b0}},
    '{'{KIND_LOOKUP, 8'h00, 20'h00000, 20'h12345}, 1'b1, '{1'b1, 20'h00000, 1'b0}},
    '{'{KIND_INSERT, 8'h00, 20'h00000, 20'hfffff}, 1'b0, '0},
    '{'{KIND_LOOKUP, 8'hff, 20'hfffff, 20'h00000}, 1'b1, '{1'b0, 20'h0, 1'b0}},
    '{'{KIND_INSERT, 8'h00, 20'h00000, 20'h00777}, 1'b0, '0},
    '{'{KIND_INSERT, 8'h5a, 20'ha5a5a, 20'h00001}, 1'b0, '0},
    '{'{KIND_INSERT, 8'h5a, 20'h5a5a5, 20'h00002}, 1'b0, '0},
    '{'{KIND_INV_PAGE, 8'h5a, 20'ha5a5a, 20'h00000}, 1'b0, '0},
    '{'{KIND_LOOKUP, 8'h5a, 20'ha5a5a, 20'h00000}, 1'b1, '{1'b0, 20'h0, 1'b0}},
    '{'{KIND_INV_PROC, 8'h5a, 20'h00000, 20'h00000}, 1'b0, '0},
    '{'{KIND_INV_FRAME, 8'h00, 20'h00000, 20'h00777}, 1'b0, '0},
    '{'{3'd5, 8'hff, 20'hfffff, 20'hfffff}, 1'b1, '{1'b0, 20'h0, 1'b0}},
    '{'{3'd7, 8'h00, 20'h00000, 20'h00000}, 1'b1, '{1'b0, 20'h0, 1'b0}}
  };

  initial begin
    op_word_t op;
    int gap;
    int burst;
    for (int k = 0; k < ENTRIES; k++) begin
      tlb_valid[k] = 1'b0;
      tlb_pid[k] = '0;
      tlb_page[k] = '0;
      tlb_frame[k] = '0;
      tlb_rank[k] = LAST_RANK;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_word(directed[i].op, directed[i].known, directed[i].res);
    // Fill past capacity with distinct frames so that eviction is exercised.
    for (int i = 0; i < ENTRIES + 4; i++) begin
      op = '{KIND_INSERT, 8'(i), 20'(i * 3), 20'(i + 100)};
      send_word(op, 1'b0, '0);
    end
    burst = 0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      send_word(random_word(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 10) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
design/ttlb_pkg.sv
design/ttlb_ctrl.sv
design/ttlb_dp.sv
design/tagged_tlb_lru.sv
tb/tagged_tlb_lru_tb.sv
